/* hw/rtl/hcpf_pkg.sv */
// Shared constants, types and fixed-point helpers for the Hertz contact force pipeline.
package hcpf_pkg;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_RADIUS_SCALE   = 2'd0;
   localparam csr_index_type CSR_MODULUS_FACTOR = 2'd1;
   localparam csr_index_type CSR_DAMPING_SCALE  = 2'd2;
   localparam csr_index_type CSR_RESTITUTION    = 2'd3;

   // Q32.32 constants
   localparam logic [63:0] K_HERTZ  = 64'd4581298450;
   localparam logic [63:0] K_DAMP   = 64'd2521145803;
   localparam logic [63:0] K_ENERGY = 64'd1717986918;
   localparam logic [63:0] K_PI     = 64'd13486197309;
   localparam logic [32:0] Q_ONE    = 33'h1_0000_0000;
   localparam logic [62:0] RADIUS_SCALE_RESET = 63'h1_0000_0000;

   localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

   // one quotient or root bit per stage
   localparam int STEPS = 64;

   // Q32.32 product: drop 32 fraction bits, saturate on overflow
   function automatic logic [63:0] q_sat(input logic [127:0] p);
      return (p[127:96] != 32'd0) ? MAX64 : p[95:32];
   endfunction

   function automatic logic [62:0] sat63(input logic [63:0] v);
      return v[63] ? MAX63 : v[62:0];
   endfunction

   // Q32.32 value scaled by 2^32 as a 128-bit dividend or radicand
   function automatic logic [127:0] q_shift(input logic [63:0] a);
      return {32'd0, a, 32'd0};
   endfunction

endpackage

/* hw/rtl/hcpf_delay.sv */
// Enable-gated delay line for operands that travel beside the arithmetic units.
module hcpf_delay #(
   parameter int Width = 1,
   parameter int Depth = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [Width-1:0] din,
   output logic [Width-1:0] dout
);

   logic [Width-1:0] tap_ff [Depth];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < Depth; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[Depth-1];

endmodule

/* hw/rtl/hcpf_mul.sv */
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module hcpf_mul (
   input  logic          clock,
   input  logic          en,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic [127:0]  p
);

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= 64'(a[31:0]) * 64'(b[31:0]);
         lh_ff <= 64'(a[31:0]) * 64'(b[63:32]);
         hl_ff <= 64'(a[63:32]) * 64'(b[31:0]);
         hh_ff <= 64'(a[63:32]) * 64'(b[63:32]);
         p_ff  <= {hh_ff, ll_ff} + ({64'd0, lh_ff} << 32) + ({64'd0, hl_ff} << 32);
      end
   end

   assign p = p_ff;

endmodule

/* hw/rtl/hcpf_div.sv */
// Pipelined restoring divider, 128-bit dividend over 64-bit divisor, one bit per stage.
module hcpf_div import hcpf_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  logic [127:0]  num,
   input  logic [63:0]   den,
   output logic [63:0]   quo
);

   logic [63:0] rem_ff [STEPS];
   logic [63:0] lo_ff  [STEPS];
   logic [63:0] q_ff   [STEPS];
   logic [63:0] d_ff   [STEPS];
   logic        sat_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic [63:0] src_rem, src_lo, src_q, src_d;
      logic        src_sat;
      logic [64:0] trial;
      logic        ge;

      if (k == 0) begin : g_first
         assign src_rem = num[127:64];
         assign src_lo  = num[63:0];
         assign src_q   = '0;
         assign src_d   = den;
         // zero divisor or quotient wider than 64 bits
         assign src_sat = (den == 64'd0) || (num[127:64] >= den);
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_lo  = lo_ff[k-1];
         assign src_q   = q_ff[k-1];
         assign src_d   = d_ff[k-1];
         assign src_sat = sat_ff[k-1];
      end

      assign trial = {src_rem, src_lo[63]};
      assign ge    = trial >= {1'b0, src_d};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? 64'(trial - {1'b0, src_d}) : trial[63:0];
            lo_ff[k]  <= src_lo << 1;
            q_ff[k]   <= {src_q[62:0], ge};
            d_ff[k]   <= src_d;
            sat_ff[k] <= src_sat;
         end
      end
   end

   assign quo = sat_ff[STEPS-1] ? MAX64 : q_ff[STEPS-1];

endmodule

/* hw/rtl/hcpf_sqrt.sv */
// Pipelined floor square root of a 128-bit value, one root bit per stage.
module hcpf_sqrt import hcpf_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  logic [127:0]  rad,
   output logic [63:0]   root
);

   logic [65:0]  rem_ff  [STEPS];
   logic [63:0]  root_ff [STEPS];
   logic [127:0] rad_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic [65:0]  src_rem;
      logic [63:0]  src_root;
      logic [127:0] src_rad;
      logic [67:0]  trial, test;
      logic         ge;

      if (k == 0) begin : g_first
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_rad  = rad;
      end else begin : g_next
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_rad  = rad_ff[k-1];
      end

      // bring down two radicand bits, try root bit one (4Q+1)
      assign trial = {src_rem, src_rad[127:126]};
      assign test  = {2'b00, src_root, 2'b01};
      assign ge    = trial >= test;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? 66'(trial - test) : trial[65:0];
            root_ff[k] <= {src_root[62:0], ge};
            rad_ff[k]  <= src_rad << 2;
         end
      end
   end

   assign root = root_ff[STEPS-1];

endmodule

/* hw/rtl/hertz_contact_pair_force.sv */
// Throughput: one pair per cycle; every stage advances together and holds while a
// response beat waits unaccepted.
// The latency is set by the chain of 64-stage divider and square-root units.
// Reset clears all valid bits and loads the configuration registers with defaults.
module hertz_contact_pair_force import hcpf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [63:0]  req_sep_x,
   input  logic signed [63:0]  req_sep_y,
   input  logic signed [63:0]  req_sep_z,
   input  logic signed [63:0]  req_relvel_x,
   input  logic signed [63:0]  req_relvel_y,
   input  logic signed [63:0]  req_relvel_z,
   input  logic [62:0]         req_radius_i,
   input  logic [62:0]         req_radius_j,
   input  logic [62:0]         req_compliance_i,
   input  logic [62:0]         req_compliance_j,
   input  logic [62:0]         req_mass_sum,
   input  logic                req_near_in_reference,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_in_contact,
   output logic signed [63:0]  rsp_force_x,
   output logic signed [63:0]  rsp_force_y,
   output logic signed [63:0]  rsp_force_z,
   output logic [62:0]         rsp_pair_energy,
   output logic [62:0]         rsp_critical_step,
   input  logic                csr_wr_en,
   input  csr_index_type       csr_index,
   input  logic [62:0]         csr_wdata
);

   localparam int PIPE_LAST = 334;

   // ---------------- configuration ----------------
   logic [62:0] radius_scale_ff, modulus_factor_ff, damping_scale_ff;
   logic [32:0] restitution_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_scale_ff   <= RADIUS_SCALE_RESET;
         modulus_factor_ff <= '0;
         damping_scale_ff  <= '0;
         restitution_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RADIUS_SCALE:   radius_scale_ff   <= csr_wdata;
            CSR_MODULUS_FACTOR: modulus_factor_ff <= csr_wdata;
            CSR_DAMPING_SCALE:  damping_scale_ff  <= csr_wdata;
            CSR_RESTITUTION:    restitution_ff    <= csr_wdata[32:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic                 en;
   logic [PIPE_LAST:0]   vld_ff;
   logic                 rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[PIPE_LAST-1:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_LAST];
      end
   end

   // ---------------- t0: magnitudes and signs ----------------
   logic [2:0][63:0] sep_w, vel_w, mag_in, vmag_in;
   logic [2:0]       neg_in, sel_in;
   logic [2:0][63:0] mag_ff, vmag_ff;
   logic [2:0]       neg_ff, sel_ff;
   logic [62:0]      rad_i_ff, rad_j_ff, mass_ff;
   logic [63:0]      comp_ff;
   logic             near_ff;

   assign sep_w = {req_sep_z, req_sep_y, req_sep_x};
   assign vel_w = {req_relvel_z, req_relvel_y, req_relvel_x};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         neg_in[c]  = sep_w[c][63];
         mag_in[c]  = sep_w[c][63] ? (~sep_w[c] + 64'd1) : sep_w[c];
         vmag_in[c] = vel_w[c][63] ? (~vel_w[c] + 64'd1) : vel_w[c];
         // product lands on the negative side when the signs differ
         sel_in[c]  = sep_w[c][63] ^ vel_w[c][63];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         vmag_ff  <= vmag_in;
         neg_ff   <= neg_in;
         sel_ff   <= sel_in;
         rad_i_ff <= req_radius_i;
         rad_j_ff <= req_radius_j;
         comp_ff  <= {1'b0, req_compliance_i} + {1'b0, req_compliance_j};
         mass_ff  <= req_mass_sum;
         near_ff  <= req_near_in_reference;
      end
   end

   // ---------------- t0 -> t2: squares, dot products, radii ----------------
   logic [2:0][127:0] sqr_t2, dot_t2;
   logic [127:0]      ri_p_t2, rj_p_t2, dca_t2;
   logic [2:0]        sel_t2;

   for (genvar c = 0; c < 3; c++) begin : g_t0
      hcpf_mul u_sqr (.clock, .en, .a(mag_ff[c]), .b(mag_ff[c]),  .p(sqr_t2[c]));
      hcpf_mul u_dot (.clock, .en, .a(mag_ff[c]), .b(vmag_ff[c]), .p(dot_t2[c]));
   end

   hcpf_mul u_ri  (.clock, .en, .a({1'b0, radius_scale_ff}), .b({1'b0, rad_i_ff}), .p(ri_p_t2));
   hcpf_mul u_rj  (.clock, .en, .a({1'b0, radius_scale_ff}), .b({1'b0, rad_j_ff}), .p(rj_p_t2));
   hcpf_mul u_dca (.clock, .en, .a({1'b0, damping_scale_ff}), .b(K_DAMP), .p(dca_t2));

   hcpf_delay #(.Width(3), .Depth(2)) u_sel_d (.clock, .en, .din(sel_ff), .dout(sel_t2));

   // ---------------- t2: sums, scaled radii ----------------
   logic [127:0] rsq_t3_ff, spos_t3_ff, sneg_t3_ff;
   logic [62:0]  ri_t3_ff, rj_t3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsq_t3_ff  <= sqr_t2[0] + sqr_t2[1] + sqr_t2[2];
         spos_t3_ff <= (sel_t2[0] ? 128'd0 : dot_t2[0]) + (sel_t2[1] ? 128'd0 : dot_t2[1])
                     + (sel_t2[2] ? 128'd0 : dot_t2[2]);
         sneg_t3_ff <= (sel_t2[0] ? dot_t2[0] : 128'd0) + (sel_t2[1] ? dot_t2[1] : 128'd0)
                     + (sel_t2[2] ? dot_t2[2] : 128'd0);
         ri_t3_ff   <= sat63(q_sat(ri_p_t2));
         rj_t3_ff   <= sat63(q_sat(rj_p_t2));
      end
   end

   // damping coefficient chain, config only
   logic [32:0]  rest_clamp, damp_keep;
   logic [127:0] dcb_t4, dck_t6;
   logic [63:0]  dck_t135;

   assign rest_clamp = (restitution_ff > Q_ONE) ? Q_ONE : restitution_ff;
   assign damp_keep  = Q_ONE - rest_clamp;

   hcpf_mul u_dcb (.clock, .en, .a(q_sat(dca_t2)), .b({31'd0, damp_keep}), .p(dcb_t4));
   hcpf_mul u_dck (.clock, .en, .a(q_sat(dcb_t4)), .b(K_HERTZ), .p(dck_t6));
   hcpf_delay #(.Width(64), .Depth(129)) u_dck_d (
      .clock, .en, .din(q_sat(dck_t6)), .dout(dck_t135));

   // ---------------- t3: cutoff squares ----------------
   logic [63:0]  rcut_t3, rh_t3, rcut_t5, rh_t5, reff_t5;
   logic         approach_t3, approach_t139;
   logic [127:0] rc2_t5, rh2_t5, rij_t5, rsq_t5;
   logic         near_t5, contact_t5, contact_t334;
   logic [63:0]  comp_t5;

   assign rcut_t3     = {1'b0, ri_t3_ff} + {1'b0, rj_t3_ff};
   assign rh_t3       = rcut_t3 >> 1;
   assign approach_t3 = spos_t3_ff < sneg_t3_ff;

   hcpf_mul u_rc2 (.clock, .en, .a(rcut_t3), .b(rcut_t3), .p(rc2_t5));
   hcpf_mul u_rh2 (.clock, .en, .a(rh_t3), .b(rh_t3), .p(rh2_t5));
   hcpf_mul u_rij (.clock, .en, .a({1'b0, ri_t3_ff}), .b({1'b0, rj_t3_ff}), .p(rij_t5));

   hcpf_delay #(.Width(192), .Depth(2)) u_t3_d (
      .clock, .en, .din({rsq_t3_ff, rcut_t3}), .dout({rsq_t5, rcut_t5}));
   hcpf_delay #(.Width(1), .Depth(136)) u_appr_d (
      .clock, .en, .din(approach_t3), .dout(approach_t139));
   hcpf_delay #(.Width(65), .Depth(5)) u_t0_d (
      .clock, .en, .din({near_ff, comp_ff}), .dout({near_t5, comp_t5}));

   // ---------------- t5: contact test, root, radius and modulus quotients ----------------
   logic [63:0] r_t69, rg_t69, e_t69, reff_t69;

   assign rh_t5      = rcut_t5 >> 1;
   assign contact_t5 = (rsq_t5 < rc2_t5) && (!near_t5 || (rsq_t5 <= rh2_t5));
   assign reff_t5    = near_t5 ? rh_t5 : rcut_t5;

   hcpf_sqrt u_r  (.clock, .en, .rad(rsq_t5), .root(r_t69));
   hcpf_div  u_rg (.clock, .en, .num(rij_t5), .den(reff_t5), .quo(rg_t69));
   hcpf_div  u_e  (.clock, .en, .num(q_shift({1'b0, modulus_factor_ff})), .den(comp_t5),
                   .quo(e_t69));

   hcpf_delay #(.Width(64), .Depth(64)) u_reff_d (
      .clock, .en, .din(reff_t5), .dout(reff_t69));
   hcpf_delay #(.Width(1), .Depth(329)) u_contact_d (
      .clock, .en, .din(contact_t5), .dout(contact_t334));

   // ---------------- t69: overlap ----------------
   logic [63:0]  delta_t69, delta_t71, delta_t140, delta_t142;
   logic [127:0] drg_t71, ke_t71, ked_t73;
   logic [63:0]  r_t137, r_t139, r_t142, r_t206;

   assign delta_t69 = reff_t69 - r_t69;

   hcpf_mul u_drg (.clock, .en, .a(delta_t69), .b(rg_t69), .p(drg_t71));
   hcpf_mul u_ke  (.clock, .en, .a(K_HERTZ), .b(e_t69), .p(ke_t71));

   hcpf_delay #(.Width(64), .Depth(2)) u_delta_d0 (
      .clock, .en, .din(delta_t69), .dout(delta_t71));
   hcpf_delay #(.Width(64), .Depth(68)) u_r_d0 (.clock, .en, .din(r_t69), .dout(r_t137));

   // ---------------- t71: contact stiffness root ----------------
   logic [63:0] sq_t135, ked_t135;

   hcpf_sqrt u_sq  (.clock, .en, .rad(q_shift(q_sat(drg_t71))), .root(sq_t135));
   hcpf_mul  u_ked (.clock, .en, .a(q_sat(ke_t71)), .b(delta_t71), .p(ked_t73));

   hcpf_delay #(.Width(64), .Depth(62)) u_ked_d (
      .clock, .en, .din(q_sat(ked_t73)), .dout(ked_t135));
   hcpf_delay #(.Width(64), .Depth(69)) u_delta_d1 (
      .clock, .en, .din(delta_t71), .dout(delta_t140));

   // ---------------- t135: Hertz and damping terms ----------------
   logic [127:0] h_t137, dsq_t137, d_t139;
   logic [63:0]  h_t139, dd_t139, f_t139, f_t140;
   logic [64:0]  fsum_t139;

   hcpf_mul u_h   (.clock, .en, .a(ked_t135), .b(sq_t135), .p(h_t137));
   hcpf_mul u_dsq (.clock, .en, .a(dck_t135), .b(sq_t135), .p(dsq_t137));
   hcpf_mul u_d   (.clock, .en, .a(q_sat(dsq_t137)), .b(r_t137), .p(d_t139));

   hcpf_delay #(.Width(64), .Depth(2)) u_h_d (.clock, .en, .din(q_sat(h_t137)), .dout(h_t139));
   hcpf_delay #(.Width(64), .Depth(2)) u_r_d1 (.clock, .en, .din(r_t137), .dout(r_t139));

   // add damping while approaching, subtract while separating, clamp at zero
   assign dd_t139   = (r_t139 == 64'd0) ? 64'd0 : q_sat(d_t139);
   assign fsum_t139 = {1'b0, h_t139} + {1'b0, dd_t139};
   assign f_t139    = approach_t139 ? (fsum_t139[64] ? MAX64 : fsum_t139[63:0])
                                    : ((h_t139 > dd_t139) ? (h_t139 - dd_t139) : 64'd0);

   hcpf_delay #(.Width(64), .Depth(1)) u_f_d (.clock, .en, .din(f_t139), .dout(f_t140));
   hcpf_delay #(.Width(64), .Depth(3)) u_r_d2 (.clock, .en, .din(r_t139), .dout(r_t142));

   // ---------------- t140: outputs from the force ----------------
   logic [2:0][63:0]  mag_t140;
   logic [2:0][127:0] fm_t142;
   logic [127:0]      fe_t142, en_t144;
   logic [63:0]       k_t204;
   logic [62:0]       pe_t334;

   hcpf_delay #(.Width(192), .Depth(140)) u_mag_d (
      .clock, .en, .din(mag_ff), .dout(mag_t140));

   for (genvar c = 0; c < 3; c++) begin : g_t140
      hcpf_mul u_fm (.clock, .en, .a(f_t140), .b(mag_t140[c]), .p(fm_t142[c]));
   end

   hcpf_mul u_fe (.clock, .en, .a(f_t140), .b(K_ENERGY), .p(fe_t142));
   hcpf_div u_k  (.clock, .en, .num(q_shift(f_t140)), .den(delta_t140), .quo(k_t204));

   hcpf_delay #(.Width(64), .Depth(2)) u_delta_d2 (
      .clock, .en, .din(delta_t140), .dout(delta_t142));

   hcpf_mul u_en (.clock, .en, .a(q_sat(fe_t142)), .b(delta_t142), .p(en_t144));
   hcpf_delay #(.Width(63), .Depth(190)) u_pe_d (
      .clock, .en, .din(sat63(q_sat(en_t144))), .dout(pe_t334));

   // ---------------- t142: force components ----------------
   logic [2:0][63:0] fq_t206, force_t206, force_t334;
   logic [2:0][62:0] fmag_t206;
   logic [2:0]       neg_t206;

   for (genvar c = 0; c < 3; c++) begin : g_t142
      hcpf_div u_fq (.clock, .en, .num(fm_t142[c]), .den(r_t142), .quo(fq_t206[c]));
   end

   hcpf_delay #(.Width(64), .Depth(64)) u_r_d3 (.clock, .en, .din(r_t142), .dout(r_t206));
   hcpf_delay #(.Width(3), .Depth(206)) u_neg_d (.clock, .en, .din(neg_ff), .dout(neg_t206));

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         fmag_t206[c]  = sat63(fq_t206[c]);
         force_t206[c] = (r_t206 == 64'd0) ? 64'd0
                       : (neg_t206[c] ? (~{1'b0, fmag_t206[c]} + 64'd1) : {1'b0, fmag_t206[c]});
      end
   end

   hcpf_delay #(.Width(192), .Depth(128)) u_force_d (
      .clock, .en, .din(force_t206), .dout(force_t334));

   // ---------------- t204: critical step ----------------
   logic [62:0]  mass_t204;
   logic [63:0]  m_t268, sr_t332;
   logic [127:0] cs_t334;

   hcpf_delay #(.Width(63), .Depth(204)) u_mass_d (
      .clock, .en, .din(mass_ff), .dout(mass_t204));

   hcpf_div  u_m  (.clock, .en, .num(q_shift({2'b00, mass_t204[62:1]})), .den(k_t204),
                   .quo(m_t268));
   hcpf_sqrt u_sr (.clock, .en, .rad(q_shift(m_t268)), .root(sr_t332));
   hcpf_mul  u_cs (.clock, .en, .a(K_PI), .b(sr_t332), .p(cs_t334));

   // ---------------- t334: response register ----------------
   logic             in_contact_ff;
   logic [2:0][63:0] force_ff;
   logic [62:0]      energy_ff, step_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         in_contact_ff <= contact_t334;
         // drop every field when the pair is out of contact
         force_ff  <= contact_t334 ? force_t334 : '0;
         energy_ff <= contact_t334 ? pe_t334 : '0;
         step_ff   <= contact_t334 ? sat63(q_sat(cs_t334)) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_in_contact    = in_contact_ff;
   assign rsp_force_x       = force_ff[0];
   assign rsp_force_y       = force_ff[1];
   assign rsp_force_z       = force_ff[2];
   assign rsp_pair_energy   = energy_ff;
   assign rsp_critical_step = step_ff;

   // ---------------- assertions ----------------
   a_no_contact_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !in_contact_ff |->
         (force_ff == '0) && (energy_ff == '0) && (step_ff == '0))
      else $error("out-of-contact beat carries nonzero payload");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (vld_ff == '0))
      else $error("valid bits survive reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff) && $stable(force_ff) && $stable(step_ff))
      else $error("pipeline moved during stall");

endmodule
